>>> hw/rtl/bitset_find_first_next_macros.svh
// Assertion macros for the bitset find-first/next block.
`ifndef BITSET_FIND_FIRST_NEXT_MACROS_SVH
`define BITSET_FIND_FIRST_NEXT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks at every clock edge that the consequent follows from the antecedent in the same cycle.
`define BSFF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BSFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BSFF_ASSERT_IMPLY(label, ante, cons)
`define BSFF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hw/rtl/bsff_pkg.sv
// Shared operation codes and field widths for the bitset find-first/next block.
package bsff_pkg;

  localparam int OP_W    = 3;
  localparam int IDX_W   = 7;
  localparam int COUNT_W = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR_ALL   = 3'd0,
    OP_SET_ALL     = 3'd1,
    OP_SET_BIT     = 3'd2,
    OP_CLEAR_BIT   = 3'd3,
    OP_TEST_BIT    = 3'd4,
    OP_FIND_FIRST  = 3'd5,
    OP_FIND_NEXT   = 3'd6
  } op_t;

endpackage

>>> hw/rtl/bitset_find_first_next.sv
// Bitmap set with population count, bit operations and priority searches.
//
// The input channel carries one operation per transfer: the opcode in in_tuser and
// the bit index in in_tdata. Each operation produces exactly one result transfer on
// the output channel with the previous bit value, a found flag, the found index and
// the population after the operation.
// The item is captured in an input register; from there the bitmap is read,
// updated and searched by one pass of logic (a lowest-set-bit isolate with a single
// wide add and an OR-tree index encoder) and the result goes to the output register.
// out_tvalid rises when the result is loaded into the output register. One operation
// is accepted every cycle while the output side keeps taking results.
// When the receiver stalls, the result waits in the output register, one more item
// waits in the input register, and in_tready drops until the output is taken.
// Reset clears the bitmap, the population and both valid flags at once.
`include "bitset_find_first_next_macros.svh"

module bitset_find_first_next
  import bsff_pkg::*;
#(
  parameter int SET_WIDTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] bit_index, [7] zero
  input  logic [OP_W-1:0]        in_tuser,   // [2:0] op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] old_bit, [1] found, [8:2] found_index,
                                             // [16:9] set_count, [23:17] zero
);

  localparam int IW = (SET_WIDTH > 1) ? $clog2(SET_WIDTH) : 1;
  localparam int CW = $clog2(SET_WIDTH + 1);
  localparam logic [SET_WIDTH-1:0] ONE = {{(SET_WIDTH-1){1'b0}}, 1'b1};

  logic                   in_valid_r;
  op_t                    op_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [SET_WIDTH-1:0]   bits_r;
  logic [SET_WIDTH-1:0]   bits_nxt;
  logic [CW-1:0]          pop_r;
  logic [CW-1:0]          pop_nxt;

  logic                   advance;
  logic                   in_range;
  logic                   next_ok;
  logic [IW-1:0]          bit_sel;
  logic [SET_WIDTH-1:0]   onehot;
  logic [SET_WIDTH-1:0]   mask_above;
  logic                   cur_bit;
  logic                   old_bit;
  logic [SET_WIDTH-1:0]   search;
  logic [SET_WIDTH-1:0]   lowest;
  logic [IW-1:0]          enc;
  logic                   found;
  logic [IDX_W-1:0]       found_index;

  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign in_range   = 32'(idx_r) < SET_WIDTH;
  assign next_ok    = (32'(idx_r) + 32'd1) < SET_WIDTH;
  assign bit_sel    = IW'(idx_r);
  assign onehot     = ONE << bit_sel;
  assign mask_above = ({SET_WIDTH{1'b1}} << bit_sel) << 1;
  assign cur_bit    = bits_r[bit_sel];

  always_comb begin
    bits_nxt = bits_r;
    pop_nxt  = pop_r;
    old_bit  = 1'b0;
    search   = '0;
    unique case (op_r)
      OP_CLEAR_ALL: begin
        bits_nxt = '0;
        pop_nxt  = '0;
      end
      OP_SET_ALL: begin
        bits_nxt = '1;
        pop_nxt  = CW'(SET_WIDTH);
      end
      OP_SET_BIT: begin
        if (in_range) begin
          old_bit  = cur_bit;
          bits_nxt = bits_r | onehot;
          if (!cur_bit) pop_nxt = pop_r + CW'(1);
        end
      end
      OP_CLEAR_BIT: begin
        if (in_range) begin
          old_bit  = cur_bit;
          bits_nxt = bits_r & ~onehot;
          if (cur_bit) pop_nxt = pop_r - CW'(1);
        end
      end
      OP_TEST_BIT: begin
        if (in_range) old_bit = cur_bit;
      end
      OP_FIND_FIRST: begin
        search = bits_r;
      end
      OP_FIND_NEXT: begin
        if (next_ok) search = bits_r & mask_above;
      end
      default: begin
      end
    endcase
  end

  // Isolate the lowest set bit, then encode its position with an OR per index bit.
  assign lowest = search & (~search + ONE);
  assign found  = |search;

  always_comb begin
    enc = '0;
    for (int i = 0; i < SET_WIDTH; i++) begin
      if (lowest[i]) enc = enc | IW'(i);
    end
  end

  assign found_index = IDX_W'(enc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bits_r      <= '0;
      pop_r       <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        bits_r      <= bits_nxt;
        pop_r       <= pop_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= op_t'(in_tuser);
      idx_r <= in_tdata[IDX_W-1:0];
    end
    if (advance) begin
      out_data_r <= {{(OUT_TDATA_W - 2 - IDX_W - COUNT_W){1'b0}}, COUNT_W'(pop_nxt),
                     found_index, found, old_bit};
    end
  end

  `BSFF_ASSERT_IMPLY(a_pop_matches_bits, 1'b1, 32'(pop_r) == $countones(bits_r))
  `BSFF_ASSERT_IMPLY(a_pop_bound, 1'b1, 32'(pop_r) <= SET_WIDTH)
  `BSFF_ASSERT_NEXT(a_result_follows, advance, out_valid_r)
  `BSFF_ASSERT_IMPLY(a_not_found_zero_index, out_valid_r && !out_data_r[1],
                     out_data_r[IDX_W+1:2] == '0)
  `BSFF_ASSERT_NEXT(a_set_all_full, advance && op_r == OP_SET_ALL,
                    32'(pop_r) == SET_WIDTH)

endmodule
